[src/rht_pkg.sv]
// Package for the RGB to HSV color threshold block.
// Holds payload and pipeline types, constants and the division step function.
// No dependencies.
package rht_pkg;

  localparam int CHAN_W   = 8;
  localparam int BOUND_W  = 9;
  localparam int QUO_W    = 9;   // quotient bits, one per division cell
  localparam int NUM_CELLS = QUO_W;
  localparam int PROD_W   = 14;  // 43 * 255 fits in 14 bits
  localparam int CFG_IDX_W = 3;

  localparam logic [5:0]         HUE_SCALE  = 6'd43;
  localparam logic [BOUND_W-1:0] HUE_OFS_G  = BOUND_W'(256 / 3);
  localparam logic [BOUND_W-1:0] HUE_OFS_B  = BOUND_W'(2 * 256 / 3);
  localparam logic [BOUND_W-1:0] HUE_WRAP   = BOUND_W'(256);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_LOW  = 3'd2,
    REG_SAT_HIGH = 3'd3,
    REG_VAL_LOW  = 3'd4,
    REG_VAL_HIGH = 3'd5
  } reg_idx_t;

  localparam logic [BOUND_W-1:0] HUE_LOW_RST  = 9'd0;
  localparam logic [BOUND_W-1:0] HUE_HIGH_RST = 9'd256;
  localparam logic [BOUND_W-1:0] SAT_LOW_RST  = 9'd0;
  localparam logic [BOUND_W-1:0] SAT_HIGH_RST = 9'd257;
  localparam logic [BOUND_W-1:0] VAL_LOW_RST  = 9'd0;
  localparam logic [BOUND_W-1:0] VAL_HIGH_RST = 9'd256;

  // Which channel is largest
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic               match;
    logic [CHAN_W-1:0]  hue;
    logic [BOUND_W-1:0] saturation;
    logic [CHAN_W-1:0]  brightness;
  } res_t;

  // One restoring-division lane: remainder, dividend bits still to shift in,
  // quotient bits produced so far
  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [QUO_W-1:0]  dvd;
    logic [QUO_W-1:0]  quo;
  } lane_t;

  // Data carried down the cell chain
  typedef struct packed {
    sector_t           sector;
    logic              neg;      // hue difference was negative
    logic [CHAN_W-1:0] top;      // largest channel, saturation divisor
    logic [CHAN_W-1:0] chroma;   // hue divisor
    lane_t             hue_ln;
    lane_t             sat_ln;
  } cell_t;

  typedef struct packed {
    logic [BOUND_W-1:0] hue_low;
    logic [BOUND_W-1:0] hue_high;
    logic [BOUND_W-1:0] sat_low;
    logic [BOUND_W-1:0] sat_high;
    logic [BOUND_W-1:0] val_low;
    logic [BOUND_W-1:0] val_high;
  } cfg_t;

  // One quotient bit: shift in the next dividend bit, subtract if it fits.
  // Relies on rem < divisor on entry.
  function automatic lane_t div_step(lane_t ln, logic [CHAN_W-1:0] divisor);
    logic [CHAN_W:0] trial;
    logic [CHAN_W:0] diff;
    lane_t           res;
    trial = {ln.rem, ln.dvd[QUO_W-1]};
    diff  = trial - {1'b0, divisor};
    res.dvd = {ln.dvd[QUO_W-2:0], 1'b0};
    if (trial >= {1'b0, divisor}) begin
      res.rem = diff[CHAN_W-1:0];
      res.quo = {ln.quo[QUO_W-2:0], 1'b1};
    end else begin
      res.rem = trial[CHAN_W-1:0];
      res.quo = {ln.quo[QUO_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

[src/rht_front.sv]
// Front stage: max/min, sector choice, chroma and scaled hue difference.
// Loads the first division lane state. Depends on rht_pkg.
module rht_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  rht_pkg::pix_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output rht_pkg::cell_t dn_data
);
  import rht_pkg::*;

  logic              valid_r;
  cell_t             data_r;
  cell_t             data_nxt;
  logic [CHAN_W-1:0] r, g, b;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W-1:0] pos_a, pos_b;   // difference taken as pos_a - pos_b
  logic [CHAN_W-1:0] mag;
  logic [PROD_W-1:0] prod;

  assign r = up_data.red;
  assign g = up_data.green;
  assign b = up_data.blue;

  // Sector, difference operands and smallest channel
  always_comb begin
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    data_nxt = '0;
    if (r > b && r > g) begin
      data_nxt.sector = SEC_RED;
      data_nxt.top    = r;
      pos_a = g;
      pos_b = b;
    end else if (g > b) begin
      data_nxt.sector = SEC_GREEN;
      data_nxt.top    = g;
      pos_a = b;
      pos_b = r;
    end else begin
      data_nxt.sector = SEC_BLUE;
      data_nxt.top    = b;
      pos_a = r;
      pos_b = g;
    end
    data_nxt.neg    = pos_b > pos_a;
    mag             = data_nxt.neg ? (pos_b - pos_a) : (pos_a - pos_b);
    prod            = PROD_W'(mag) * PROD_W'(HUE_SCALE);
    data_nxt.chroma = data_nxt.top - mn;
    // Hue quotient is below 2^9, so the top dividend bits start as remainder
    data_nxt.hue_ln.rem = CHAN_W'(prod[PROD_W-1:QUO_W]);
    data_nxt.hue_ln.dvd = prod[QUO_W-1:0];
    data_nxt.hue_ln.quo = '0;
    // Saturation dividend is chroma * 256
    data_nxt.sat_ln.rem = {1'b0, data_nxt.chroma[CHAN_W-1:1]};
    data_nxt.sat_ln.dvd = {data_nxt.chroma[0], {(QUO_W-1){1'b0}}};
    data_nxt.sat_ln.quo = '0;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[src/rht_div_cell.sv]
// One division cell: produces one hue and one saturation quotient bit.
// Identical cells form the chain. Depends on rht_pkg.
module rht_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  rht_pkg::cell_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output rht_pkg::cell_t dn_data
);
  import rht_pkg::*;

  logic  valid_r;
  cell_t data_r;
  cell_t data_nxt;

  // Both lanes step in parallel; side data passes along
  always_comb begin
    data_nxt        = up_data;
    data_nxt.hue_ln = div_step(up_data.hue_ln, up_data.chroma);
    data_nxt.sat_ln = div_step(up_data.sat_ln, up_data.top);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[src/rht_back.sv]
// Back stage: hue offset and wrap, zero cases, window test, output register.
// Depends on rht_pkg.
module rht_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  rht_pkg::cell_t up_data,
  input  rht_pkg::cfg_t  cfg,
  output logic           out_valid,
  input  logic           out_stall,
  output rht_pkg::res_t  out_data
);
  import rht_pkg::*;

  logic               valid_r;
  res_t               data_r;
  res_t               data_nxt;
  logic [BOUND_W-1:0] q;
  logic [BOUND_W-1:0] hue9;
  logic [BOUND_W-1:0] sat9;
  logic [BOUND_W-1:0] val9;

  // Hue from the truncated quotient magnitude and sector
  always_comb begin
    q = up_data.hue_ln.quo;
    if (up_data.chroma == '0) begin
      hue9 = '0;
    end else begin
      case (up_data.sector)
        SEC_RED:   hue9 = (up_data.neg && q != '0) ? (HUE_WRAP - q) : q;
        SEC_GREEN: hue9 = up_data.neg ? (HUE_OFS_G - q) : (HUE_OFS_G + q);
        default:   hue9 = up_data.neg ? (HUE_OFS_B - q) : (HUE_OFS_B + q);
      endcase
    end
    sat9 = (up_data.top == '0) ? '0 : up_data.sat_ln.quo;
    val9 = {1'b0, up_data.top};

    data_nxt.hue        = hue9[CHAN_W-1:0];
    data_nxt.saturation = sat9;
    data_nxt.brightness = up_data.top;
    data_nxt.match      = (hue9 > cfg.hue_low) && (hue9 < cfg.hue_high) &&
                          (sat9 > cfg.sat_low) && (sat9 < cfg.sat_high) &&
                          (val9 > cfg.val_low) && (val9 < cfg.val_high);
  end

  assign up_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[src/rgb_hsv_color_threshold.sv]
// Top level of the RGB to HSV color threshold block.
// Uses rht_pkg, rht_front, rht_div_cell and rht_back.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one 8-bit RGB pixel per
//   transfer. Result channel out_valid/out_stall/out_data carries one result
//   per pixel: match bit, hue (0..255), saturation (0..256), brightness.
//   Results leave in pixel order.
//   From input transfer to out_valid, a pixel passes the front stage, which
//   loads at the transfer edge, then nine division cells (one quotient bit
//   each for hue and saturation) and the output register.
//   Throughput is one pixel per clock; every stage is a register with its
//   own valid, so a new pixel enters each cycle while the chain is moving.
//   When the receiver stalls, the output register holds its result and the
//   stall backs up stage by stage; empty stages keep filling, so in_stall
//   rises only once all stages hold pixels.
//   Configuration: cfg_we writes cfg_wdata to the bound register cfg_index
//   (hue, saturation, value lower/upper exclusive bounds); unknown indexes
//   are ignored. Write only while the block is empty.
//   Synchronous reset empties the pipeline and restores default bounds.
module rgb_hsv_color_threshold (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rht_pkg::pix_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rht_pkg::res_t                  out_data,
  input  logic                           cfg_we,
  input  logic [rht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rht_pkg::BOUND_W-1:0]    cfg_wdata
);
  import rht_pkg::*;

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;

  logic  front_ready;
  logic  front_valid;
  cell_t front_data;

  logic  chain_valid [NUM_CELLS+1];
  logic  chain_ready [NUM_CELLS+1];
  cell_t chain_data  [NUM_CELLS+1];

  // Bound register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HUE_LOW:  cfg_nxt.hue_low  = cfg_wdata;
        REG_HUE_HIGH: cfg_nxt.hue_high = cfg_wdata;
        REG_SAT_LOW:  cfg_nxt.sat_low  = cfg_wdata;
        REG_SAT_HIGH: cfg_nxt.sat_high = cfg_wdata;
        REG_VAL_LOW:  cfg_nxt.val_low  = cfg_wdata;
        REG_VAL_HIGH: cfg_nxt.val_high = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hue_low  <= HUE_LOW_RST;
      cfg_r.hue_high <= HUE_HIGH_RST;
      cfg_r.sat_low  <= SAT_LOW_RST;
      cfg_r.sat_high <= SAT_HIGH_RST;
      cfg_r.val_low  <= VAL_LOW_RST;
      cfg_r.val_high <= VAL_HIGH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = !front_ready;

  rht_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .up_data  (in_data),
    .dn_valid (front_valid),
    .dn_ready (chain_ready[0]),
    .dn_data  (front_data)
  );

  assign chain_valid[0] = front_valid;
  assign chain_data[0]  = front_data;

  // Division cell chain
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rht_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  rht_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (chain_valid[NUM_CELLS]),
    .up_ready  (chain_ready[NUM_CELLS]),
    .up_data   (chain_data[NUM_CELLS]),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[src/rht_checker.sv]
// Port-level checks for the RGB to HSV color threshold block, bound to the
// top level. Depends on rht_pkg.
module rht_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input rht_pkg::pix_t                 in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input rht_pkg::res_t                 out_data
);
  import rht_pkg::*;

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled input pixel stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input pixel changed while stalled");

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.brightness == '0 |->
      out_data.hue == '0 && out_data.saturation == '0)
    else $error("nonzero hue or saturation for black pixel");

  // Saturation never exceeds full scale
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.saturation <= BOUND_W'(256))
    else $error("saturation out of range");

endmodule

bind rgb_hsv_color_threshold rht_checker u_rht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
